/* rtl/scl_pkg.sv */
// Package for the scalar-to-color lookup block: payload, configuration and
// pipeline types, register indexes and reset values.
// No dependencies; every other file of the block but scl_ram imports it.
package scl_pkg;

  // Default sizes handed to the top level's parameters.
  localparam int unsigned DEF_TABLE_DEPTH = 256;
  localparam int unsigned DEF_MAX_REPEAT  = 8;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Texture coordinate of one in Q1.16.
  localparam logic [16:0] COORD_ONE = 17'h10000;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_MAP   = 1'b1
  } cmd_e;

  typedef enum logic {
    MODE_COLOR = 1'b0,
    MODE_COORD = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALUE_MIN        = 3'd0,
    REG_INDEX_SCALE      = 3'd1,
    REG_STEPS_IN_USE     = 3'd2,
    REG_NODATA_THRESHOLD = 3'd3,
    REG_NODATA_COLOR     = 3'd4,
    REG_REPEAT_COUNT     = 3'd5,
    REG_OUT_MODE         = 3'd6,
    REG_COORD_SCALE      = 3'd7
  } cfg_reg_e;

  // Input transaction.
  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  entry_index;
    logic [31:0] entry_color;
    logic [31:0] sample;
  } in_item_t;

  // Output transaction.
  typedef struct packed {
    logic [31:0] color;
    logic [16:0] tex_coord;
    logic        last;
  } out_item_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [31:0] value_min;
    logic [31:0] index_scale;
    logic [8:0]  steps_in_use;
    logic [31:0] nodata_threshold;
    logic [31:0] nodata_color;
    logic [3:0]  repeat_count;
    mode_e       out_mode;
    logic [31:0] coord_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    value_min:        32'h0000_0000,
    index_scale:      32'h0100_0000,
    steps_in_use:     9'd256,
    nodata_threshold: 32'h7FFF_FFFF,
    nodata_color:     32'h0000_0000,
    repeat_count:     4'd1,
    out_mode:         MODE_COLOR,
    coord_scale:      32'h0001_0000
  };

  // Side information of a map transaction leaving the index pipeline.
  typedef struct packed {
    logic        valid;
    logic        is_coord;
    logic        nodata;
    logic [16:0] tex_coord;
  } look_info_t;

endpackage

/* rtl/scl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module scl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/scl_cfg_regs.sv */
// Configuration register file of the scalar-to-color lookup block.
// Depends on scl_pkg for the register indexes and reset values.
module scl_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [scl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [scl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output scl_pkg::cfg_t                    cfg_o
);
  import scl_pkg::*;

  cfg_t cfg_d, cfg_q;

  // Decode the write into the addressed field.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_VALUE_MIN:        cfg_d.value_min        = cfg_wdata_i;
        REG_INDEX_SCALE:      cfg_d.index_scale      = cfg_wdata_i;
        REG_STEPS_IN_USE:     cfg_d.steps_in_use     = cfg_wdata_i[8:0];
        REG_NODATA_THRESHOLD: cfg_d.nodata_threshold = cfg_wdata_i;
        REG_NODATA_COLOR:     cfg_d.nodata_color     = cfg_wdata_i;
        REG_REPEAT_COUNT:     cfg_d.repeat_count     = cfg_wdata_i[3:0];
        REG_OUT_MODE:         cfg_d.out_mode         = mode_e'(cfg_wdata_i[0]);
        REG_COORD_SCALE:      cfg_d.coord_scale      = cfg_wdata_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/scl_index_pipe.sv */
// Three-stage front pipeline: offset and no-data test, scale multiply,
// index clamp and coordinate saturation; drives the colour table ports.
// Depends on scl_pkg for the transaction and configuration types.
module scl_index_pipe #(
  parameter int unsigned TABLE_DEPTH = scl_pkg::DEF_TABLE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           accept_i,
  input  scl_pkg::in_item_t              item_i,
  input  scl_pkg::cfg_t                  cfg_i,
  output logic                           ram_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr_o,
  output logic [31:0]                    ram_wdata_o,
  output logic                           ram_re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr_o,
  output scl_pkg::look_info_t            info_o
);
  import scl_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  // Stage 1 registers.
  logic        s1_valid_d, s1_valid_q;
  logic        s1_map_d, s1_map_q;
  logic        s1_coord_d, s1_coord_q;
  logic        s1_nodata_d, s1_nodata_q;
  logic        s1_wr_ok_d, s1_wr_ok_q;
  logic [31:0] s1_op_d, s1_op_q;
  logic [7:0]  s1_waddr_q;
  logic [31:0] s1_wdata_q;
  logic [32:0] diff;

  // Stage 2 registers.
  logic        s2_valid_q, s2_map_q, s2_coord_q, s2_nodata_q, s2_wr_ok_q;
  logic [63:0] s2_prod_d, s2_prod_q;
  logic [7:0]  s2_waddr_q;
  logic [31:0] s2_wdata_q;
  logic [31:0] scale_sel;

  // Stage 3 registers.
  logic          s3_valid_q, s3_map_q, s3_coord_q, s3_nodata_q, s3_wr_ok_q;
  logic [AW-1:0] s3_idx_d, s3_idx_q;
  logic [16:0]   s3_tex_d, s3_tex_q;
  logic [7:0]    s3_waddr_q;
  logic [31:0]   s3_wdata_q;
  logic [31:0]   steps_eff;
  logic [31:0]   max_idx;
  logic [31:0]   idx_full;
  logic [31:0]   idx_clamped;

  // Stage 1: exact offset from the range minimum and the no-data compare.
  always_comb begin
    diff        = {item_i.sample[31], item_i.sample}
                - {cfg_i.value_min[31], cfg_i.value_min};
    s1_valid_d  = accept_i;
    s1_map_d    = (item_i.cmd == CMD_MAP);
    s1_coord_d  = (cfg_i.out_mode == MODE_COORD);
    s1_nodata_d = (cfg_i.out_mode == MODE_COLOR) &&
                  ($signed(item_i.sample) >= $signed(cfg_i.nodata_threshold));
    s1_wr_ok_d  = (32'(item_i.entry_index) < 32'(TABLE_DEPTH));
    // Non-positive offsets map to index and coordinate zero.
    s1_op_d     = (!diff[32] && (diff != 33'd0)) ? diff[31:0] : 32'd0;
  end

  // Stage 2: one 32 by 32 product with the scale for the current mode.
  always_comb begin
    scale_sel = s1_coord_q ? cfg_i.coord_scale : cfg_i.index_scale;
    s2_prod_d = 64'(s1_op_q) * 64'(scale_sel);
  end

  // Stage 3: clamp the index to the steps in use and saturate the coordinate.
  always_comb begin
    steps_eff = 32'(cfg_i.steps_in_use);
    if (steps_eff == 32'd0) begin
      steps_eff = 32'd1;
    end else if (steps_eff > 32'(TABLE_DEPTH)) begin
      steps_eff = 32'(TABLE_DEPTH);
    end
    max_idx     = steps_eff - 32'd1;
    idx_full    = s2_prod_q[63:32];
    idx_clamped = (idx_full > max_idx) ? max_idx : idx_full;
    s3_idx_d    = idx_clamped[AW-1:0];
    if (!s2_coord_q) begin
      s3_tex_d = 17'd0;
    end else if (s2_prod_q[63:16] > 48'(COORD_ONE)) begin
      s3_tex_d = COORD_ONE;
    end else begin
      s3_tex_d = s2_prod_q[32:16];
    end
  end

  // Valid bits travel with the data; the whole pipeline moves on en_i.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Payload registers of all three stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_map_q    <= s1_map_d;
      s1_coord_q  <= s1_coord_d;
      s1_nodata_q <= s1_nodata_d;
      s1_wr_ok_q  <= s1_wr_ok_d;
      s1_op_q     <= s1_op_d;
      s1_waddr_q  <= item_i.entry_index;
      s1_wdata_q  <= item_i.entry_color;

      s2_map_q    <= s1_map_q;
      s2_coord_q  <= s1_coord_q;
      s2_nodata_q <= s1_nodata_q;
      s2_wr_ok_q  <= s1_wr_ok_q;
      s2_prod_q   <= s2_prod_d;
      s2_waddr_q  <= s1_waddr_q;
      s2_wdata_q  <= s1_wdata_q;

      s3_map_q    <= s2_map_q;
      s3_coord_q  <= s2_coord_q;
      s3_nodata_q <= s2_nodata_q;
      s3_wr_ok_q  <= s2_wr_ok_q;
      s3_idx_q    <= s3_idx_d;
      s3_tex_q    <= s3_tex_d;
      s3_waddr_q  <= s2_waddr_q;
      s3_wdata_q  <= s2_wdata_q;
    end
  end

  // Table writes and reads both happen at stage 3, which keeps them in order.
  assign ram_we_o    = en_i && s3_valid_q && !s3_map_q && s3_wr_ok_q;
  assign ram_waddr_o = AW'(s3_waddr_q);
  assign ram_wdata_o = s3_wdata_q;
  assign ram_re_o    = en_i && s3_valid_q && s3_map_q;
  assign ram_raddr_o = s3_idx_q;

  assign info_o.valid     = s3_valid_q && s3_map_q;
  assign info_o.is_coord  = s3_coord_q;
  assign info_o.nodata    = s3_nodata_q;
  assign info_o.tex_coord = s3_tex_q;

endmodule

/* rtl/scl_out_stage.sv */
// Table read stage and output register with the repeat counter; produces
// the pipeline advance enable.
// Depends on scl_pkg for the transaction, configuration and info types.
module scl_out_stage #(
  parameter int unsigned MAX_REPEAT = scl_pkg::DEF_MAX_REPEAT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scl_pkg::cfg_t        cfg_i,
  input  scl_pkg::look_info_t  info_i,
  input  logic [31:0]          ram_rdata_i,
  output logic                 en_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output scl_pkg::out_item_t   out_data_o
);
  import scl_pkg::*;

  localparam int unsigned RPT_W = $clog2(MAX_REPEAT + 1);

  look_info_t  s4_q;
  logic        out_valid_d, out_valid_q;
  logic [RPT_W-1:0] rem_d, rem_q;
  logic [31:0] color_d, color_q;
  logic [16:0] tex_d, tex_q;
  logic [31:0] reps;
  logic        last;

  assign last = (rem_q == '0);

  // The pipeline advances when the output register is empty or hands over
  // its final copy.
  assign en_o = !out_valid_q || (out_ready_i && last);

  // Copies per sample, limited to one through MAX_REPEAT.
  always_comb begin
    reps = 32'(cfg_i.repeat_count);
    if (reps == 32'd0) begin
      reps = 32'd1;
    end else if (reps > 32'(MAX_REPEAT)) begin
      reps = 32'(MAX_REPEAT);
    end
  end

  // Next state of the output register and repeat counter.
  always_comb begin
    out_valid_d = out_valid_q;
    rem_d       = rem_q;
    color_d     = color_q;
    tex_d       = tex_q;
    if (en_o) begin
      out_valid_d = s4_q.valid;
      if (s4_q.is_coord) begin
        rem_d   = '0;
        color_d = 32'd0;
      end else begin
        rem_d   = RPT_W'(reps - 32'd1);
        color_d = s4_q.nodata ? cfg_i.nodata_color : ram_rdata_i;
      end
      tex_d = s4_q.tex_coord;
    end else if (out_ready_i) begin
      rem_d = rem_q - RPT_W'(1);
    end
  end

  // Stage 4 side information lines up with the registered table data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q        <= '0;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      if (en_o) begin
        s4_q <= info_i;
      end
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
    end
  end

  // Output payload registers.
  always_ff @(posedge clk_i) begin
    color_q <= color_d;
    tex_q   <= tex_d;
  end

  assign out_valid_o          = out_valid_q;
  assign out_data_o.color     = color_q;
  assign out_data_o.tex_coord = tex_q;
  assign out_data_o.last      = last;

endmodule

/* rtl/scalar_to_color_lookup.sv */
// Top level of the scalar-to-color lookup block.
// Depends on scl_pkg, scl_cfg_regs, scl_index_pipe, scl_ram and scl_out_stage.
//
// Usage:
// The input channel (in_valid_i, in_ready_o, in_data_i) carries commands: a
// write command stores entry_color at entry_index of the colour table, a map
// command converts one Q16.16 sample. The output channel (out_valid_o,
// out_ready_i, out_data_o) returns the results; a write command returns none.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i with no wait; the user must write them only while the block is
// idle, which the block does not enforce. A map transaction passes the offset,
// multiply, clamp, table read and output registers before its first result is
// shown. A new transaction is accepted in every cycle as long as each sample
// yields one result and the receiver takes every result; in colour mode with a
// repeat count r, held to one through MAX_REPEAT, the output register shows r
// copies, one per cycle while the receiver takes them; input is held meanwhile.
// Reset clears all control state and loads the register defaults at once;
// the colour table is not cleared and must be written before it is read.
// When the receiver stalls, the output register holds its copy and the
// whole pipeline freezes; nothing is lost or repeated.
module scalar_to_color_lookup #(
  parameter int unsigned TABLE_DEPTH = scl_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned MAX_REPEAT  = scl_pkg::DEF_MAX_REPEAT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  scl_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output scl_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [scl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [scl_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import scl_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  cfg_t          cfg;
  look_info_t    info;
  logic          en;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  assign in_ready_o = en;

  scl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  scl_index_pipe #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_index (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .accept_i    (in_valid_i && en),
    .item_i      (in_data_i),
    .cfg_i       (cfg),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .info_o      (info)
  );

  scl_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  scl_out_stage #(
    .MAX_REPEAT (MAX_REPEAT)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .info_i      (info),
    .ram_rdata_i (ram_rdata),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/scl_checker.sv */
// Port-level checks of the scalar-to-color lookup block and their binding.
// Depends on scl_pkg and the top level scalar_to_color_lookup.
module scl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input scl_pkg::out_item_t out_data_o
);
  import scl_pkg::*;

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // Once reset has been seen at an edge, no result is shown.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // Input is held while copies of a sample remain to be sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input accepted during a repeat burst");

  // A burst continues after a copy that is not the last is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)
    else $error("repeat burst ended early");

  // Only one of colour and coordinate is used, and the coordinate stays in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.color == 32'd0 || out_data_o.tex_coord == 17'd0) &&
                    (out_data_o.tex_coord <= COORD_ONE))
    else $error("output fields inconsistent");

endmodule

bind scalar_to_color_lookup scl_checker u_scl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* tb/sv/scalar_to_color_lookup_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for scalar_to_color_lookup: directed and random table
// write and map transactions, checked against a behavioural colour map model.
// Depends on scl_pkg and the scalar_to_color_lookup RTL.
module scalar_to_color_lookup_tb;
  import scl_pkg::*;

  localparam int unsigned DEPTH         = DEF_TABLE_DEPTH;
  localparam int unsigned REPEAT_MAX    = DEF_MAX_REPEAT;
  localparam int unsigned ITEM_TARGET   = 270;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic [31:0] Q_MIN         = 32'h8000_0000;
  localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Model of the block: register contents, colour table and pending results.
  cfg_t        lut_cfg = CFG_RESET;
  logic [31:0] lut_entries [DEPTH];
  bit          lut_written [DEPTH];
  out_item_t   results_due [$];
  out_item_t   due;

  int errors       = 0;
  int items_sent   = 0;
  int maps_sent    = 0;
  int coords_sent  = 0;
  int results_seen = 0;
  bit no_gaps      = 1'b0;

  scalar_to_color_lookup uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Table slot that a sample selects under the current settings, after clamping.
  function automatic int lookup_slot(logic [31:0] sample);
    longint      offset;
    logic [63:0] span;
    logic [63:0] prod;
    logic [63:0] slot;
    int          steps;
    offset = longint'($signed(sample)) - longint'($signed(lut_cfg.value_min));
    steps  = int'(lut_cfg.steps_in_use);
    if (steps < 1) steps = 1;
    if (steps > DEPTH) steps = DEPTH;
    slot = '0;
    if (offset > 0) begin
      span = offset;
      prod = span * {32'd0, lut_cfg.index_scale};
      slot = prod >> 32;
    end
    if (slot > 64'(steps - 1)) slot = 64'(steps - 1);
    return int'(slot);
  endfunction

  // Applies one accepted transaction to the model and queues the results it causes.
  function automatic void lookup_results(in_item_t item);
    longint      offset;
    logic [63:0] span;
    logic [63:0] prod;
    logic [16:0] coord;
    logic [31:0] colour;
    int          reps;
    out_item_t   res;
    if (item.cmd == CMD_WRITE) begin
      lut_entries[item.entry_index] = item.entry_color;
      lut_written[item.entry_index] = 1'b1;
      return;
    end
    maps_sent++;
    offset = longint'($signed(item.sample)) - longint'($signed(lut_cfg.value_min));
    if (lut_cfg.out_mode == MODE_COORD) begin
      // One saturated coordinate; the no-data threshold plays no part here.
      coord = '0;
      if (offset > 0) begin
        span = offset;
        prod = (span * {32'd0, lut_cfg.coord_scale}) >> 16;
        coord = (prod > {47'd0, COORD_ONE}) ? COORD_ONE : prod[16:0];
      end
      res.color     = '0;
      res.tex_coord = coord;
      res.last      = 1'b1;
      results_due.insert(results_due.size(), res);
      coords_sent++;
      return;
    end
    reps = int'(lut_cfg.repeat_count);
    if (reps < 1) reps = 1;
    if (reps > REPEAT_MAX) reps = REPEAT_MAX;
    if ($signed(item.sample) >= $signed(lut_cfg.nodata_threshold)) begin
      colour = lut_cfg.nodata_color;
    end else begin
      colour = lut_entries[lookup_slot(item.sample)];
    end
    for (int k = 0; k < reps; k++) begin
      res.color     = colour;
      res.tex_coord = '0;
      res.last      = (k == reps - 1);
      results_due.insert(results_due.size(), res);
    end
  endfunction

  // Presents one transaction and waits until it is accepted. Valid is left high
  // so that a following transaction with no gap goes out in the next cycle.
  task automatic send_item(in_item_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    lookup_results(item);
    items_sent++;
  endtask

  task automatic send_write(int slot, logic [31:0] colour);
    in_item_t item;
    item.cmd         = CMD_WRITE;
    item.entry_index = slot[7:0];
    item.entry_color = colour;
    item.sample      = $urandom();
    send_item(item);
  endtask

  // A map transaction; the slot it reads is written first if it is still empty.
  task automatic send_map(logic [31:0] sample);
    in_item_t item;
    int       slot;
    slot = lookup_slot(sample);
    if (!lut_written[slot]) send_write(slot, $urandom());
    item.cmd         = CMD_MAP;
    item.entry_index = 8'($urandom_range(0, DEPTH - 1));
    item.entry_color = $urandom();
    item.sample      = sample;
    send_item(item);
  endtask

  // Stops sending and waits until every result has come and the pipeline is empty.
  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes every register, one per cycle, with junk above the narrow fields.
  task automatic apply_config(cfg_t c);
    cfg_reg_e    reg_idx;
    logic [31:0] junk;
    logic [31:0] value;
    wait_idle();
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      reg_idx = cfg_reg_e'(i);
      junk    = $urandom();
      case (reg_idx)
        REG_VALUE_MIN:        value = c.value_min;
        REG_INDEX_SCALE:      value = c.index_scale;
        REG_STEPS_IN_USE:     value = {junk[31:9], c.steps_in_use};
        REG_NODATA_THRESHOLD: value = c.nodata_threshold;
        REG_NODATA_COLOR:     value = c.nodata_color;
        REG_REPEAT_COUNT:     value = {junk[31:4], c.repeat_count};
        REG_OUT_MODE:         value = {junk[31:1], c.out_mode};
        default:              value = c.coord_scale;
      endcase
      cfg_we    <= 1'b1;
      cfg_idx   <= reg_idx;
      cfg_wdata <= value;
      @(posedge clk_i);
    end
    cfg_we  <= 1'b0;
    lut_cfg = c;
  endtask

  // Reset settings: index is the offset divided by 256 raw units.
  task automatic test_default_settings();
    send_map(32'h0000_0000);
    send_map(32'hFFFF_0000);
    send_map(32'h0000_0100);
    send_map(32'h0000_8000);
    send_map(32'h0001_0000);
    send_map(Q_MAX);
    send_map(32'h7FFF_FFFE);
    // Overwrite a slot and read it back straight away.
    send_write(1, $urandom());
    send_map(32'h0000_0100);
  endtask

  // Widest data range, full scale, and no-data thresholds at the top and at zero.
  task automatic test_range_extremes();
    cfg_t c;
    c = CFG_RESET;
    c.value_min        = Q_MIN;
    c.index_scale      = 32'hFFFF_FFFF;
    c.nodata_color     = $urandom();
    c.repeat_count     = 4'd8;
    apply_config(c);
    send_map(Q_MIN);
    send_map(Q_MIN + 32'd1);
    send_map(32'h0000_0000);
    send_map(Q_MAX);
    c.value_min        = Q_MAX;
    c.index_scale      = 32'h0000_0000;
    c.nodata_threshold = 32'h0000_0000;
    c.repeat_count     = 4'd2;
    apply_config(c);
    send_map(32'hFFFF_FFFF);
    send_map(32'h0000_0000);
    send_map(Q_MIN);
  endtask

  // Steps and repeat counts outside their valid ranges.
  task automatic test_register_limits();
    cfg_t c;
    c = CFG_RESET;
    c.steps_in_use = 9'd0;
    c.repeat_count = 4'd0;
    apply_config(c);
    send_map(32'h0001_0000);
    c.steps_in_use = 9'd511;
    c.repeat_count = 4'd15;
    apply_config(c);
    send_map(32'h7FFF_0000);
    send_map(32'h0000_0100);
  endtask

  // Texture coordinates: below range, saturation, and a zero scale.
  task automatic test_coord_mode();
    cfg_t c;
    c = CFG_RESET;
    c.out_mode         = MODE_COORD;
    c.coord_scale      = 32'hFFFF_FFFF;
    c.nodata_threshold = Q_MIN;
    c.repeat_count     = 4'd5;
    apply_config(c);
    send_map(Q_MIN);
    send_map(32'h0000_0000);
    send_map(32'h0000_0001);
    send_map(32'h0000_0002);
    send_map(Q_MAX);
    c.value_min   = Q_MIN;
    c.coord_scale = 32'h0001_0000;
    apply_config(c);
    send_map(Q_MIN + 32'h0000_8000);
    c.coord_scale = 32'h0000_0000;
    apply_config(c);
    send_map(Q_MAX);
  endtask

  // Settings for one random phase; span is the raw width of the data range.
  function automatic cfg_t random_config(output longint span);
    cfg_t        c;
    logic [31:0] rnd;
    longint      steps;
    longint      scale;
    int          r;
    span = (longint'(1) << $urandom_range(10, 31)) + $urandom_range(0, 1023);
    rnd  = $urandom();
    r    = $urandom_range(0, 9);
    c.value_min = (r == 0) ? Q_MIN : (r == 1) ? $urandom() : {{12{rnd[19]}}, rnd[19:0]};
    r = $urandom_range(0, 9);
    case (r)
      0:       c.steps_in_use = 9'd0;
      1:       c.steps_in_use = 9'($urandom_range(257, 511));
      2:       c.steps_in_use = 9'd256;
      3:       c.steps_in_use = 9'd1;
      default: c.steps_in_use = 9'($urandom_range(2, 255));
    endcase
    steps = longint'(c.steps_in_use);
    if (steps < 1) steps = 1;
    if (steps > DEPTH) steps = DEPTH;
    scale = (steps << 32) / span;
    c.index_scale = ($urandom_range(0, 7) == 0) ? $urandom() :
                    (scale > longint'(Q_MAX) * 2 + 1) ? 32'hFFFF_FFFF : 32'(scale);
    r = $urandom_range(0, 3);
    c.nodata_threshold = (r == 0) ? Q_MAX : (r == 1) ? $urandom() :
                         32'(longint'($signed(c.value_min)) + span - span / 8);
    c.nodata_color = $urandom();
    r = $urandom_range(0, 9);
    c.repeat_count = (r == 0) ? 4'd0 : (r == 1) ? 4'($urandom_range(9, 15)) :
                     4'($urandom_range(1, 8));
    c.out_mode = ($urandom_range(0, 3) == 0) ? MODE_COORD : MODE_COLOR;
    scale = (longint'(1) << 48) / span;
    c.coord_scale = ($urandom_range(0, 7) == 0) ? $urandom() :
                    (scale > longint'(Q_MAX) * 2 + 1) ? 32'hFFFF_FFFF : 32'(scale);
    return c;
  endfunction

  // Samples mostly inside the data range, some at the threshold, some anywhere.
  function automatic logic [31:0] random_sample(cfg_t c, longint span);
    longint off;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom();
    if (r < 20) return c.nodata_threshold + 32'($urandom_range(0, 2)) - 32'd1;
    off = longint'($urandom_range(0, 32'(span + span / 8))) - span / 16;
    return 32'(longint'($signed(c.value_min)) + off);
  endfunction

  task automatic test_random_traffic();
    cfg_t   c;
    longint span;
    int     phase;
    int     phase_items;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      c = random_config(span);
      apply_config(c);
      no_gaps     = (phase == 2);
      phase_items = $urandom_range(15, 40);
      for (int n = 0; n < phase_items; n++) begin
        // Once, the sender holds back until everything has drained.
        if (phase == 1 && n == phase_items / 2) wait_idle();
        if ($urandom_range(0, 99) < 20) send_write($urandom_range(0, DEPTH - 1), $urandom());
        else send_map(random_sample(c, span));
      end
      no_gaps = 1'b0;
      phase++;
    end
  endtask

  // Receiver side: random stalls on the output channel.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (no_gaps) begin
        out_ready <= 1'b1;
      end else if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // Each result transaction is compared with the oldest pending one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        $error("unexpected result: color %h tex_coord %h last %b",
               out_data.color, out_data.tex_coord, out_data.last);
        errors++;
      end else begin
        due = results_due.pop_front();
        if (out_data.color !== due.color) begin
          $error("color: expected %h, got %h", due.color, out_data.color);
          errors++;
        end
        if (out_data.tex_coord !== due.tex_coord) begin
          $error("tex_coord: expected %h, got %h", due.tex_coord, out_data.tex_coord);
          errors++;
        end
        if (out_data.last !== due.last) begin
          $error("last: expected %b, got %b", due.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout with %0d results outstanding", results_due.size());
    $display("scalar_to_color_lookup_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_settings();
    test_range_extremes();
    test_register_limits();
    test_coord_mode();
    test_random_traffic();
    wait_idle();
    $display("%0d transactions sent, %0d of them maps (%0d as texture coordinates);",
             items_sent, maps_sent, coords_sent);
    $display("%0d results checked over directed and random register settings.",
             results_seen);
    if (errors == 0 && results_due.size() == 0) begin
      $display("scalar_to_color_lookup_tb: done, clean");
    end else begin
      $display("scalar_to_color_lookup_tb: done, errors");
    end
    $finish;
  end

endmodule
